// ----- rtl/core/tfpl_pkg.sv -----
// Shared types, codes and constants of the triangle fan point locator.
// No dependencies; used by every module of the block.
`default_nettype none

package tfpl_pkg;

  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_FAN_SIZE     = 12;

  localparam int IDX_W    = 12;
  localparam int SLOT_W   = 4;
  localparam int COORD_W  = 32;
  localparam int AREA_W   = 62;
  localparam int SUB_W    = 63;
  localparam int WEIGHT_W = 17;
  localparam int TOL_W    = 20;

  localparam logic [TOL_W-1:0]    TOL_RESET   = 20'd110;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'd65536;
  localparam logic [SUB_W-1:0]    AREA_CLAMP  = (63'd1 << 62) + (63'd1 << 21);

  // mode codes (s_tuser)
  localparam logic [1:0] MODE_VERTEX = 2'd0;
  localparam logic [1:0] MODE_FAN    = 2'd1;
  localparam logic [1:0] MODE_LOCATE = 2'd2;

  // result status codes (m_tuser[1:0])
  localparam logic [1:0] ST_INSIDE   = 2'd0;
  localparam logic [1:0] ST_INTERIOR = 2'd1;
  localparam logic [1:0] ST_BOUNDARY = 2'd2;

  // register index on the APB port (paddr[2])
  localparam logic REG_AREA_TOL = 1'b0;

  // s_tdata bit offsets
  localparam int IN_V_LO    = 0;
  localparam int IN_SLOT_LO = 12;
  localparam int IN_X_LO    = 16;
  localparam int IN_Y_LO    = 48;
  localparam int IN_BND     = 80;
  localparam int IN_B_LO    = 81;
  localparam int IN_C_LO    = 93;
  localparam int IN_AREA_LO = 105;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VREQ,
    S_VLATCH,
    S_FREQ,
    S_FLATCH,
    S_BLATCH,
    S_CLATCH,
    S_MUL,
    S_MDRAIN,
    S_TEST,
    S_FBREQ,
    S_FBLATCH,
    S_DSTART,
    S_DWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [WEIGHT_W-1:0] q;
  } div_rsp_t;

  // Join two signed 64-bit magnitudes into |p1 - p2|, clamped.
  function automatic logic [SUB_W-1:0] sub_area_join(input logic [63:0] m1,
                                                     input logic        n1,
                                                     input logic [63:0] m2,
                                                     input logic        n2);
    logic [64:0] s;
    logic [63:0] d;
    s = 65'(m1) + 65'(m2);
    d = (m1 >= m2) ? (m1 - m2) : (m2 - m1);
    if (n1 != n2) begin
      if (s > 65'(AREA_CLAMP)) return AREA_CLAMP;
      return s[SUB_W-1:0];
    end
    if (d > 64'(AREA_CLAMP)) return AREA_CLAMP;
    return d[SUB_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tfpl_div.sv -----
// Restoring divider for one Q1.16 weight: floor(part*65536/whole), saturated.
// Depends on tfpl_pkg.
`default_nettype none

module tfpl_div
  import tfpl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUB_W-1:0]  part,
  input  wire logic [AREA_W-1:0] whole,
  output div_rsp_t               rsp
);

  logic [SUB_W-1:0]    rem;
  logic [WEIGHT_W-1:0] quo;
  logic [4:0]          cnt;
  logic                busy;
  logic                done;
  logic [SUB_W-1:0]    rem_sh;

  assign rem_sh = {rem[SUB_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (part >= SUB_W'(whole)) begin
          quo  <= WEIGHT_ONE;
          done <= 1'b1;
        end else begin
          rem  <= part;
          quo  <= '0;
          cnt  <= 5'd16;
          busy <= 1'b1;
        end
      end else if (busy) begin
        // one quotient bit per cycle
        if (rem_sh >= SUB_W'(whole)) begin
          rem <= rem_sh - SUB_W'(whole);
          quo <= {quo[WEIGHT_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[WEIGHT_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = quo;

endmodule

`default_nettype wire

// ----- rtl/core/triangle_fan_point_locate.sv -----
// Triangle fan point locator: vertex and fan tables in block memory, one
// locate sequencer with a shared 32x32 multiplier and a serial divider.
// Depends on tfpl_pkg and tfpl_div.
`default_nettype none

// Load beats (mode 0 vertex, mode 1 fan triangle) are written straight into
// the vertex memory or the fan memory. A locate beat walks the fan of its
// nearest vertex in slot order; all reads go through the single registered
// read port of each memory. A locate first fetches the nearest vertex, then
// for each fan triangle tried reads the fan entry, reads the two corners,
// forms six products through one multiplier and runs the area test. A hit
// adds three weight divisions through one restoring divider (a saturating
// weight finishes early), then the output state. With no hit, slot 0 is read
// back for the corners, then the output state follows. A nearest vertex at
// or above MAX_VERTICES goes straight to the output state with the fallback
// result. The input side takes a new beat as soon as the sequencer is idle,
// while the previous result may still wait in the output register. Tables
// have no reset: read only entries written first. Configuration register
// area_tolerance sits at byte address 0 of the APB port and may only be
// written while the block is idle.

module triangle_fan_point_locate
  import tfpl_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int FAN_SIZE     = DEF_FAN_SIZE
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // vertex_index[11:0], slot[15:12], coord_x[47:16], coord_y[79:48],
  // on_boundary[80], corner_b[92:81], corner_c[104:93],
  // doubled_area[166:105], zero[167]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  wire logic [1:0]            s_tuser,
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // found_second[11:0], found_third[23:12], weight_first[40:24],
  // weight_second[57:41], weight_third[74:58], zero[79:75]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // result_status[1:0], outside_domain[2]
  output logic [2:0]                 m_tuser,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int VW        = $clog2(MAX_VERTICES);
  localparam int FAN_DEPTH = MAX_VERTICES * FAN_SIZE;
  localparam int FW        = $clog2(FAN_DEPTH);
  localparam int TW        = (FAN_SIZE > 1) ? $clog2(FAN_SIZE) : 1;
  localparam int VMEM_W    = 2 * COORD_W + 1;
  localparam int FMEM_W    = AREA_W + 2 * IDX_W;

  // ---------------------------------------------------------------- config
  logic [TOL_W-1:0] area_tol;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_tol <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_AREA_TOL) begin
      area_tol <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_AREA_TOL) ? {{(32-TOL_W){1'b0}}, area_tol} : 32'd0;

  // ---------------------------------------------------------- input fields
  logic [IDX_W-1:0]   in_v;
  logic [SLOT_W-1:0]  in_slot;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic               in_bnd;
  logic [IDX_W-1:0]   in_b;
  logic [IDX_W-1:0]   in_c;
  logic [AREA_W-1:0]  in_area;
  logic               in_fire;

  assign in_v    = s_tdata[IN_V_LO    +: IDX_W];
  assign in_slot = s_tdata[IN_SLOT_LO +: SLOT_W];
  assign in_x    = s_tdata[IN_X_LO    +: COORD_W];
  assign in_y    = s_tdata[IN_Y_LO    +: COORD_W];
  assign in_bnd  = s_tdata[IN_BND];
  assign in_b    = s_tdata[IN_B_LO    +: IDX_W];
  assign in_c    = s_tdata[IN_C_LO    +: IDX_W];
  assign in_area = s_tdata[IN_AREA_LO +: AREA_W];
  assign in_fire = s_tvalid && s_tready;

  // -------------------------------------------------------------- memories
  // Writes happen only in IDLE and read data is used only during a locate, so a
  // write and a read of the same entry never overlap: no forwarding needed.
  logic [VMEM_W-1:0] vmem [MAX_VERTICES];
  logic [FMEM_W-1:0] fmem [FAN_DEPTH];
  logic [VMEM_W-1:0] vq;
  logic [FMEM_W-1:0] fq;
  logic [VW-1:0]     vrd_addr;
  logic [FW-1:0]     frd_addr;
  logic              vwr_en;
  logic              fwr_en;
  logic [FW-1:0]     fwr_addr;

  assign vwr_en   = in_fire && s_tuser == MODE_VERTEX && int'(in_v) < MAX_VERTICES;
  assign fwr_en   = in_fire && s_tuser == MODE_FAN && int'(in_v) < MAX_VERTICES &&
                    int'(in_slot) < FAN_SIZE;
  assign fwr_addr = FW'(int'(in_v) * FAN_SIZE + int'(in_slot));

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[VW'(in_v)] <= {in_bnd, in_y, in_x};
    end
    vq <= vmem[vrd_addr];
  end

  always_ff @(posedge clk) begin
    if (fwr_en) begin
      fmem[fwr_addr] <= {in_area, in_c, in_b};
    end
    fq <= fmem[frd_addr];
  end

  // ------------------------------------------------------ locate registers
  state_t state, state_next;

  logic signed [COORD_W-1:0] px, py, x1, y1, x2, y2, x3, y3;
  logic [IDX_W-1:0]  loc_v;
  logic [FW-1:0]     base;
  logic [TW-1:0]     t;
  logic [IDX_W-1:0]  cur_b, cur_c;
  logic [AREA_W-1:0] cur_area;
  logic              bnd;
  logic              found;
  logic [2:0]        k;
  logic [1:0]        j;
  logic [63:0]       prod;
  logic              pneg;
  logic [2:0]        pk;
  logic              pv;
  logic [63:0]       m1;
  logic              n1;
  logic [SUB_W-1:0]  sa [3];
  logic [WEIGHT_W-1:0] w [3];

  // shared multiplier operand select
  logic [1:0]               ai;
  logic signed [COORD_W-1:0] ax, ay, bx, by;
  logic signed [COORD_W:0]  da, db;
  logic [COORD_W-1:0]       mag_a, mag_b;
  logic [63:0]              mul_out;

  always_comb begin
    ai = k[2:1];
    ax = (ai == 2'd0) ? x2 : x1;
    ay = (ai == 2'd0) ? y2 : y1;
    bx = (ai == 2'd2) ? x2 : x3;
    by = (ai == 2'd2) ? y2 : y3;
    if (!k[0]) begin
      da = 33'(px) - 33'(ax);
      db = 33'(py) - 33'(by);
    end else begin
      da = 33'(py) - 33'(ay);
      db = 33'(px) - 33'(bx);
    end
    mag_a = da[COORD_W] ? COORD_W'(-da) : da[COORD_W-1:0];
    mag_b = db[COORD_W] ? COORD_W'(-db) : db[COORD_W-1:0];
  end

  assign mul_out = mag_a * mag_b;

  // area test
  logic [63:0] sa_sum;
  logic [63:0] area_lim;
  logic        hit;

  assign sa_sum   = 64'(sa[0]) + 64'(sa[1]) + 64'(sa[2]);
  assign area_lim = 64'(cur_area) + 64'(area_tol);
  assign hit      = (cur_area != '0) && (sa_sum <= area_lim);

  // divider
  logic     div_start;
  div_rsp_t div_rsp;

  tfpl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .part  (sa[j]),
    .whole (cur_area),
    .rsp   (div_rsp)
  );

  logic out_load;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // ------------------------------------------------------------ next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire && s_tuser == MODE_LOCATE) begin
          state_next = (int'(in_v) < MAX_VERTICES) ? S_VREQ : S_OUT;
        end
      end
      S_VREQ:    state_next = S_VLATCH;
      S_VLATCH:  state_next = S_FREQ;
      S_FREQ:    state_next = S_FLATCH;
      S_FLATCH:  state_next = S_BLATCH;
      S_BLATCH:  state_next = S_CLATCH;
      S_CLATCH:  state_next = S_MUL;
      S_MUL:     state_next = (k == 3'd5) ? S_MDRAIN : S_MUL;
      S_MDRAIN:  state_next = S_TEST;
      S_TEST: begin
        if (hit) begin
          state_next = S_DSTART;
        end else if (t == TW'(FAN_SIZE - 1)) begin
          state_next = S_FBREQ;
        end else begin
          state_next = S_FREQ;
        end
      end
      S_FBREQ:   state_next = S_FBLATCH;
      S_FBLATCH: state_next = S_OUT;
      S_DSTART:  state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          state_next = (j == 2'd2) ? S_OUT : S_DSTART;
        end
      end
      S_OUT:     state_next = out_load ? S_IDLE : S_OUT;
      default:   state_next = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    vrd_addr  = VW'(loc_v);
    frd_addr  = base;
    case (state)
      S_IDLE:   s_tready  = 1'b1;
      S_FREQ:   frd_addr  = base + FW'(t);
      S_FLATCH: vrd_addr  = VW'(fq[IDX_W-1:0]);
      S_BLATCH: vrd_addr  = VW'(cur_c);
      S_DSTART: div_start = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= (state == S_MUL);
    end
  end

  // ------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire && s_tuser == MODE_LOCATE) begin
          px    <= in_x;
          py    <= in_y;
          loc_v <= in_v;
          base  <= FW'(int'(in_v) * FAN_SIZE);
          t     <= '0;
          found <= 1'b0;
          bnd   <= 1'b0;
          cur_b <= '0;
          cur_c <= '0;
        end
      end
      S_VLATCH: begin
        x1  <= vq[COORD_W-1:0];
        y1  <= vq[2*COORD_W-1:COORD_W];
        bnd <= vq[2*COORD_W];
      end
      S_FLATCH: begin
        cur_b    <= fq[IDX_W-1:0];
        cur_c    <= fq[2*IDX_W-1:IDX_W];
        cur_area <= fq[FMEM_W-1:2*IDX_W];
      end
      S_BLATCH: begin
        // a corner index outside the table reads as the origin
        x2 <= (int'(cur_b) < MAX_VERTICES) ? vq[COORD_W-1:0] : '0;
        y2 <= (int'(cur_b) < MAX_VERTICES) ? vq[2*COORD_W-1:COORD_W] : '0;
      end
      S_CLATCH: begin
        x3 <= (int'(cur_c) < MAX_VERTICES) ? vq[COORD_W-1:0] : '0;
        y3 <= (int'(cur_c) < MAX_VERTICES) ? vq[2*COORD_W-1:COORD_W] : '0;
        k  <= '0;
      end
      S_MUL: begin
        k <= k + 3'd1;
      end
      S_TEST: begin
        if (hit) begin
          found <= 1'b1;
          j     <= '0;
        end else begin
          t <= t + TW'(1);
        end
      end
      S_FBLATCH: begin
        cur_b <= fq[IDX_W-1:0];
        cur_c <= fq[2*IDX_W-1:IDX_W];
      end
      S_DWAIT: begin
        if (div_rsp.done) begin
          w[j] <= div_rsp.q;
          j    <= j + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // product register, then fold each pair of products into a sub-area
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= mul_out;
      pneg <= da[COORD_W] ^ db[COORD_W];
      pk   <= k;
    end
    if (pv) begin
      if (!pk[0]) begin
        m1 <= prod;
        n1 <= pneg;
      end else begin
        sa[pk[2:1]] <= sub_area_join(m1, n1, prod, pneg);
      end
    end
  end

  // -------------------------------------------------------- output register
  logic [1:0] o_status;
  logic       o_outside;
  logic [IDX_W-1:0]    o_b, o_c;
  logic [WEIGHT_W-1:0] o_w1, o_w2, o_w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_b <= cur_b;
      o_c <= cur_c;
      if (found) begin
        o_status  <= ST_INSIDE;
        o_outside <= 1'b0;
        o_w1      <= w[0];
        o_w2      <= w[1];
        o_w3      <= w[2];
      end else begin
        o_status  <= bnd ? ST_BOUNDARY : ST_INTERIOR;
        o_outside <= bnd;
        o_w1      <= WEIGHT_ONE;
        o_w2      <= '0;
        o_w3      <= '0;
      end
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 2*IDX_W - 3*WEIGHT_W){1'b0}}, o_w3, o_w2, o_w1, o_c, o_b};
  assign m_tuser = {o_outside, o_status};

  // ------------------------------------------------------------ assertions
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output state");

  a_fallback_weights: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] != ST_INSIDE) |->
      (o_w1 == WEIGHT_ONE && o_w2 == '0 && o_w3 == '0))
    else $error("fallback result with non-unit weights");

  a_outside_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == ST_BOUNDARY)))
    else $error("outside flag disagrees with status");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_idle_only: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tuser == MODE_LOCATE) |=> state != S_IDLE)
    else $error("locate beat accepted but sequencer stayed idle");

endmodule

`default_nettype wire
